FILE: hdl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, token codes and keyword constants for the tokenizer.
// ----------------------------------------------------------------------------
package pst_pkg;

    // field widths of the transaction payloads
    localparam int LINE_BITS   = 16;
    localparam int NUMBER_BITS = 32;
    localparam int LENGTH_BITS = 8;
    localparam int KIND_BITS   = 5;
    localparam int PREFIX_BITS = 56;

    // token kinds
    localparam logic [KIND_BITS-1:0] K_EOF     = 5'd0;
    localparam logic [KIND_BITS-1:0] K_NUMBER  = 5'd1;
    localparam logic [KIND_BITS-1:0] K_IDENT   = 5'd2;
    localparam logic [KIND_BITS-1:0] K_PROGRAM = 5'd3;
    localparam logic [KIND_BITS-1:0] K_VAR     = 5'd4;
    localparam logic [KIND_BITS-1:0] K_BEGIN   = 5'd5;
    localparam logic [KIND_BITS-1:0] K_INTEGER = 5'd6;
    localparam logic [KIND_BITS-1:0] K_END     = 5'd7;
    localparam logic [KIND_BITS-1:0] K_DIV     = 5'd8;
    localparam logic [KIND_BITS-1:0] K_COMMA   = 5'd9;
    localparam logic [KIND_BITS-1:0] K_PERIOD  = 5'd10;
    localparam logic [KIND_BITS-1:0] K_COLON   = 5'd11;
    localparam logic [KIND_BITS-1:0] K_SEMI    = 5'd12;
    localparam logic [KIND_BITS-1:0] K_EQUAL   = 5'd13;
    localparam logic [KIND_BITS-1:0] K_PLUS    = 5'd14;
    localparam logic [KIND_BITS-1:0] K_MINUS   = 5'd15;
    localparam logic [KIND_BITS-1:0] K_STAR    = 5'd16;
    localparam logic [KIND_BITS-1:0] K_LPAREN  = 5'd17;
    localparam logic [KIND_BITS-1:0] K_RPAREN  = 5'd18;
    localparam logic [KIND_BITS-1:0] K_ASSIGN  = 5'd19;
    localparam logic [KIND_BITS-1:0] K_UNKNOWN = 5'd20;

    // byte classes
    localparam logic [2:0] CLS_BLANK   = 3'd0;
    localparam logic [2:0] CLS_NEWLINE = 3'd1;
    localparam logic [2:0] CLS_DIGIT   = 3'd2;
    localparam logic [2:0] CLS_ALPHA   = 3'd3;
    localparam logic [2:0] CLS_PUNCT   = 3'd4;
    localparam logic [2:0] CLS_OTHER   = 3'd5;

    // scanner modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_WORD   = 2'd2;
    localparam logic [1:0] MODE_COLON  = 2'd3;

    // keywords, first byte in the most significant position
    localparam logic [PREFIX_BITS-1:0] KW_PROGRAM = 56'h70726f6772616d;
    localparam logic [PREFIX_BITS-1:0] KW_VAR     = 56'h766172;
    localparam logic [PREFIX_BITS-1:0] KW_BEGIN   = 56'h626567696e;
    localparam logic [PREFIX_BITS-1:0] KW_INTEGER = 56'h696e7465676572;
    localparam logic [PREFIX_BITS-1:0] KW_END     = 56'h656e64;
    localparam logic [PREFIX_BITS-1:0] KW_DIV     = 56'h646976;

    localparam logic [LENGTH_BITS-1:0] PREFIX_CHARS = LENGTH_BITS'(7);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [KIND_BITS-1:0]   token_kind;
        logic [LINE_BITS-1:0]   token_line;
        logic [LENGTH_BITS-1:0] token_length;
        logic [NUMBER_BITS-1:0] number_value;
        logic                   last_of_run;
    } t_out;

    // classified byte passed from front to back
    typedef struct packed {
        logic [2:0]           cls;
        logic [KIND_BITS-1:0] punct_kind;
        logic [7:0]           text_byte;
        logic                 end_of_text;
    } t_item;

    function automatic logic [KIND_BITS-1:0] word_kind(
        input logic [PREFIX_BITS-1:0] prefix,
        input logic [LENGTH_BITS-1:0] len
    );
        logic [KIND_BITS-1:0] kind;
        kind = K_IDENT;
        if (len == LENGTH_BITS'(7) && prefix == KW_PROGRAM) kind = K_PROGRAM;
        if (len == LENGTH_BITS'(3) && prefix == KW_VAR)     kind = K_VAR;
        if (len == LENGTH_BITS'(5) && prefix == KW_BEGIN)   kind = K_BEGIN;
        if (len == LENGTH_BITS'(7) && prefix == KW_INTEGER) kind = K_INTEGER;
        if (len == LENGTH_BITS'(3) && prefix == KW_END)     kind = K_END;
        if (len == LENGTH_BITS'(3) && prefix == KW_DIV)     kind = K_DIV;
        return kind;
    endfunction

endpackage

FILE: hdl/pst_front.sv
// ----------------------------------------------------------------------------
// pst_front
// Input stage: takes bytes, sorts them into classes and hands them to the queue.
// ----------------------------------------------------------------------------
module pst_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pst_pkg::t_in  i_in_data,
    output logic          o_push,
    output pst_pkg::t_item o_item,
    input  logic          i_push_ready
);

    logic           r_valid;
    pst_pkg::t_item r_item;
    pst_pkg::t_item n_item;
    logic           load;

    always_comb begin
        n_item             = '0;
        n_item.text_byte   = i_in_data.text_byte;
        n_item.end_of_text = i_in_data.end_of_text;
        n_item.punct_kind  = pst_pkg::K_UNKNOWN;
        if (i_in_data.text_byte == 8'h20 || i_in_data.text_byte == 8'h09 ||
            i_in_data.text_byte == 8'h0d) begin
            n_item.cls = pst_pkg::CLS_BLANK;
        end else if (i_in_data.text_byte == 8'h0a) begin
            n_item.cls = pst_pkg::CLS_NEWLINE;
        end else if (i_in_data.text_byte >= 8'h30 && i_in_data.text_byte <= 8'h39) begin
            n_item.cls = pst_pkg::CLS_DIGIT;
        end else if ((i_in_data.text_byte >= 8'h61 && i_in_data.text_byte <= 8'h7a) ||
                     (i_in_data.text_byte >= 8'h41 && i_in_data.text_byte <= 8'h5a)) begin
            n_item.cls = pst_pkg::CLS_ALPHA;
        end else if ((i_in_data.text_byte >= 8'd33  && i_in_data.text_byte <= 8'd47) ||
                     (i_in_data.text_byte >= 8'd58  && i_in_data.text_byte <= 8'd64) ||
                     (i_in_data.text_byte >= 8'd91  && i_in_data.text_byte <= 8'd96) ||
                     (i_in_data.text_byte >= 8'd123 && i_in_data.text_byte <= 8'd126)) begin
            n_item.cls = pst_pkg::CLS_PUNCT;
        end else begin
            n_item.cls = pst_pkg::CLS_OTHER;
        end

        unique case (i_in_data.text_byte)
            8'h2c:   n_item.punct_kind = pst_pkg::K_COMMA;
            8'h2e:   n_item.punct_kind = pst_pkg::K_PERIOD;
            8'h3a:   n_item.punct_kind = pst_pkg::K_COLON;
            8'h3b:   n_item.punct_kind = pst_pkg::K_SEMI;
            8'h3d:   n_item.punct_kind = pst_pkg::K_EQUAL;
            8'h2b:   n_item.punct_kind = pst_pkg::K_PLUS;
            8'h2d:   n_item.punct_kind = pst_pkg::K_MINUS;
            8'h2a:   n_item.punct_kind = pst_pkg::K_STAR;
            8'h28:   n_item.punct_kind = pst_pkg::K_LPAREN;
            8'h29:   n_item.punct_kind = pst_pkg::K_RPAREN;
            default: n_item.punct_kind = pst_pkg::K_UNKNOWN;
        endcase
    end

    // stage register moves whenever the queue takes its content or it is empty
    assign load       = !r_valid || i_push_ready;
    assign o_in_stall = !load;
    assign o_push     = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: hdl/pst_queue.sv
// ----------------------------------------------------------------------------
// pst_queue
// Small FIFO of classified bytes between the front and back stages.
// ----------------------------------------------------------------------------
module pst_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pst_pkg::t_item i_item,
    output logic           o_push_ready,
    output logic           o_valid,
    output pst_pkg::t_item o_item,
    input  logic           i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pst_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_valid      = r_count != '0;
    assign o_item       = r_mem[r_head];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_tail <= (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
            end
            if (do_pop) begin
                r_head <= (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_item;
        end
    end

endmodule

FILE: hdl/pst_back.sv
// ----------------------------------------------------------------------------
// pst_back
// Scanner state and token builder; issues up to two tokens per byte.
// ----------------------------------------------------------------------------
module pst_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pst_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pst_pkg::t_out  o_out_data
);

    localparam int LB = pst_pkg::LINE_BITS;
    localparam int NB = pst_pkg::NUMBER_BITS;
    localparam int GB = pst_pkg::LENGTH_BITS;
    localparam int PB = pst_pkg::PREFIX_BITS;

    logic [1:0]    r_mode, n_mode;
    logic [LB-1:0] r_line, n_line;
    logic [GB-1:0] r_len, n_len;
    logic [PB-1:0] r_prefix, n_prefix;
    logic [NB-1:0] r_acc, n_acc;

    logic          r_out_valid;
    pst_pkg::t_out r_out;
    logic          r_pend_valid;
    pst_pkg::t_out r_pend;

    logic          out_free;
    logic          pop;
    logic          has_flush;
    logic          has_second;
    pst_pkg::t_out flush_tok;
    pst_pkg::t_out second_tok;
    pst_pkg::t_out tok0;
    logic [GB-1:0] len_inc;
    logic [NB+3:0] acc_ext;
    logic [NB-1:0] acc_next;
    logic [PB-1:0] prefix_next;
    logic          is_digit;
    logic          is_alpha;
    logic          is_equal;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = i_valid && out_free && !r_pend_valid;
    assign o_pop    = pop;

    assign is_digit = i_item.cls == pst_pkg::CLS_DIGIT;
    assign is_alpha = i_item.cls == pst_pkg::CLS_ALPHA;
    assign is_equal = i_item.cls == pst_pkg::CLS_PUNCT &&
                      i_item.punct_kind == pst_pkg::K_EQUAL;

    // saturating length, times ten plus digit with overflow caught in the top bits
    assign len_inc  = (r_len == '1) ? r_len : r_len + GB'(1);
    assign acc_ext  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                      (NB + 4)'(i_item.text_byte[3:0]);
    assign acc_next = (acc_ext[NB+3:NB] != 4'b0) ? '1 : acc_ext[NB-1:0];
    assign prefix_next = (r_len < pst_pkg::PREFIX_CHARS) ?
                         {r_prefix[PB-9:0], i_item.text_byte} : r_prefix;

    always_comb begin
        flush_tok              = '0;
        flush_tok.token_line   = r_line;
        flush_tok.token_length = r_len;
        unique case (r_mode)
            pst_pkg::MODE_NUMBER: begin
                flush_tok.token_kind   = pst_pkg::K_NUMBER;
                flush_tok.number_value = r_acc;
            end
            pst_pkg::MODE_WORD: begin
                flush_tok.token_kind = pst_pkg::word_kind(r_prefix, r_len);
            end
            pst_pkg::MODE_COLON: begin
                flush_tok.token_kind   = pst_pkg::K_COLON;
                flush_tok.token_length = GB'(1);
            end
            default: begin
                flush_tok.token_kind = pst_pkg::K_EOF;
            end
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_line     = r_line;
        n_len      = r_len;
        n_prefix   = r_prefix;
        n_acc      = r_acc;
        has_flush  = 1'b0;
        has_second = 1'b0;
        second_tok            = '0;
        second_tok.token_line = r_line;
        second_tok.token_kind = pst_pkg::K_EOF;

        if (i_item.end_of_text) begin
            has_flush  = r_mode != pst_pkg::MODE_IDLE;
            has_second = 1'b1;
            n_mode     = pst_pkg::MODE_IDLE;
            n_line     = LB'(1);
            n_len      = '0;
            n_prefix   = '0;
            n_acc      = '0;
        end else if (r_mode == pst_pkg::MODE_NUMBER && is_digit) begin
            n_acc = acc_next;
            n_len = len_inc;
        end else if (r_mode == pst_pkg::MODE_WORD && (is_alpha || is_digit)) begin
            n_prefix = prefix_next;
            n_len    = len_inc;
        end else if (r_mode == pst_pkg::MODE_COLON && is_equal) begin
            n_mode                  = pst_pkg::MODE_IDLE;
            has_second              = 1'b1;
            second_tok.token_kind   = pst_pkg::K_ASSIGN;
            second_tok.token_length = GB'(2);
        end else begin
            has_flush = r_mode != pst_pkg::MODE_IDLE;
            n_mode    = pst_pkg::MODE_IDLE;
            unique case (i_item.cls)
                pst_pkg::CLS_BLANK: begin
                end
                pst_pkg::CLS_NEWLINE: begin
                    if (r_line != '1) begin
                        n_line = r_line + LB'(1);
                    end
                end
                pst_pkg::CLS_DIGIT: begin
                    n_mode = pst_pkg::MODE_NUMBER;
                    n_len  = GB'(1);
                    n_acc  = NB'(i_item.text_byte[3:0]);
                end
                pst_pkg::CLS_ALPHA: begin
                    n_mode   = pst_pkg::MODE_WORD;
                    n_len    = GB'(1);
                    n_prefix = PB'(i_item.text_byte);
                end
                pst_pkg::CLS_PUNCT: begin
                    if (i_item.punct_kind == pst_pkg::K_COLON) begin
                        n_mode = pst_pkg::MODE_COLON;
                    end else begin
                        has_second              = 1'b1;
                        second_tok.token_kind   = i_item.punct_kind;
                        second_tok.token_length = GB'(1);
                    end
                end
                default: begin
                    has_second            = 1'b1;
                    second_tok.token_kind = pst_pkg::K_UNKNOWN;
                end
            endcase
        end

        second_tok.last_of_run = 1'b1;
        if (has_flush) begin
            tok0             = flush_tok;
            tok0.last_of_run = !has_second;
        end else begin
            tok0 = second_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pst_pkg::MODE_IDLE;
            r_line   <= LB'(1);
            r_len    <= '0;
            r_prefix <= '0;
            r_acc    <= '0;
        end else if (pop) begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_len    <= n_len;
            r_prefix <= n_prefix;
            r_acc    <= n_acc;
        end
    end

    // output register plus one slot for the second token of a byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (pop && (has_flush || has_second)) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= has_flush && has_second;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (pop) begin
                r_out  <= tok0;
                r_pend <= second_tok;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("second token held without a first");

    a_value_only_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.token_kind != pst_pkg::K_NUMBER) |->
        r_out.number_value == '0)
        else $error("value on a token that is not a number");

    a_eof_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.token_kind == pst_pkg::K_EOF) |->
        (r_out.last_of_run && r_out.token_length == '0))
        else $error("eof token malformed");

    a_no_pop_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !pop)
        else $error("byte consumed while a token is still pending");

endmodule

FILE: hdl/pascal_subset_tokenizer.sv
// ----------------------------------------------------------------------------
// pascal_subset_tokenizer
// Streaming lexer for a small Pascal subset, one source byte per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one byte of source text or an end-of-text
// marker. Blanks are dropped, newlines advance the line count, digit runs
// become number tokens, letter/digit runs become identifiers or keywords,
// and punctuation, ':=' and unknown bytes become their own tokens. A byte
// that closes a pending run and has a token of its own yields two tokens:
// the run first, then its own; last_of_run marks the final token from each
// byte. End of text flushes the pending run, issues an eof token and resets
// the line count to one. Throughput is one byte per clock as long as the
// output does not stall and each byte yields at most one token; a byte that
// yields two holds back the next byte while its second token waits in the
// pending slot, since the output carries one token per cycle. On its way a
// byte passes the front stage register, the queue and the output register,
// which holds its token. A queue of QUEUE_DEPTH classified bytes sits between
// the classifier and the scanner so either side can stall independently.
// ----------------------------------------------------------------------------
module pascal_subset_tokenizer #(
    parameter int QUEUE_DEPTH = 4   // 2 and up
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pst_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pst_pkg::t_out o_out_data
);

    // front to queue
    logic           push;
    logic           push_ready;
    pst_pkg::t_item front_item;

    // queue to back
    logic           q_valid;
    logic           q_pop;
    pst_pkg::t_item q_item;

    // classify the byte and register it
    pst_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_push       (push),
        .o_item       (front_item),
        .i_push_ready (push_ready)
    );

    // decoupling queue
    pst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (front_item),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_item       (q_item),
        .i_pop        (q_pop)
    );

    // scanner state, token assembly and output staging
    pst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
